// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PSBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ----- rtl/psbc_pkg.sv -----
package psbc_pkg;

    localparam int COORD_BITS = 24;
    localparam int ABS_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * ABS_BITS;
    localparam int CNT_BITS   = $clog2(ABS_BITS);
    localparam int CFG_BITS   = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [ABS_BITS-1:0]          mag_t;
    typedef logic [PROD_BITS-1:0]         prod_t;

    typedef enum logic [CFG_BITS-1:0] {
        CFG_MIN_X = 2'd0,
        CFG_MAX_X = 2'd1,
        CFG_MIN_Y = 2'd2,
        CFG_MAX_Y = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_SETUP,
        ST_MUL,
        ST_CHOOSE,
        ST_DIV,
        ST_RES,
        ST_FIN
    } psbc_state_t;

    typedef struct packed {
        logic   mode;
        coord_t point_x;
        coord_t point_y;
    } psbc_in_t;

    typedef struct packed {
        coord_t seg_start_x;
        coord_t seg_start_y;
        coord_t seg_end_x;
        coord_t seg_end_y;
        logic   start_was_clipped;
        logic   end_was_clipped;
        logic   opens_polyline;
        logic   closes_polyline;
    } psbc_out_t;

    function automatic mag_t absdiff(input coord_t a, input coord_t b);
        logic signed [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return d[COORD_BITS] ? mag_t'(-d) : mag_t'(d);
    endfunction

endpackage

// ----- rtl/psbc_mul.sv -----
module psbc_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  psbc_pkg::mag_t  a,
    input  psbc_pkg::mag_t  b,
    output logic            done,
    output psbc_pkg::prod_t product
);
    import psbc_pkg::*;

    prod_t               prod_reg;
    mag_t                mcand_reg;
    logic                busy_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [ABS_BITS:0]   sum;

    assign sum     = {1'b0, prod_reg[PROD_BITS-1:ABS_BITS]}
                   + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
    assign done    = busy_reg && (cnt_reg == CNT_BITS'(ABS_BITS - 1));
    assign product = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg  <= {{ABS_BITS{1'b0}}, b};
            mcand_reg <= a;
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum, prod_reg[ABS_BITS-1:1]};
        end
    end

endmodule

// ----- rtl/psbc_div.sv -----
module psbc_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  psbc_pkg::prod_t num,
    input  psbc_pkg::mag_t  den,
    output logic            done,
    output psbc_pkg::mag_t  quot
);
    import psbc_pkg::*;

    mag_t                rem_reg;
    mag_t                quot_reg;
    mag_t                den_reg;
    logic                busy_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [ABS_BITS:0]   trial;
    logic                ge;

    assign trial = {rem_reg, quot_reg[ABS_BITS-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign done  = busy_reg && (cnt_reg == CNT_BITS'(ABS_BITS - 1));
    assign quot  = (den_reg == '0) ? '0 : quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num[PROD_BITS-1:ABS_BITS];
            quot_reg <= num[ABS_BITS-1:0];
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? mag_t'(trial - {1'b0, den_reg}) : mag_t'(trial);
            quot_reg <= {quot_reg[ABS_BITS-2:0], ge};
        end
    end

endmodule

// ----- rtl/polyline_segment_box_clipper_top.sv -----
// A move or a skipped draw runs ST_CLASS; an unclipped draw goes on to ST_FIN; a clipped
// draw adds ST_SETUP, ST_MUL, ST_CHOOSE, ST_DIV and ST_RES around the bit-serial multiply
// and divide before ST_FIN. Throughput: one word at a time; the input is freed on return to
// ST_IDLE, later while a result waits in ST_FIN for a full output register to be taken.
// A finished result waits in the output register while the next word is worked on.
// Reset (rst_n, asynchronous, active low) zeroes the box and pen and marks a new polyline.
module polyline_segment_box_clipper_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  psbc_pkg::psbc_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output psbc_pkg::psbc_out_t                 out_data,
    input  logic                                cfg_we,
    input  logic [psbc_pkg::CFG_BITS-1:0]       cfg_index,
    input  psbc_pkg::coord_t                    cfg_data
);
    import psbc_pkg::*;

    psbc_state_t state_reg, state_next;

    coord_t box_min_x_reg, box_max_x_reg, box_min_y_reg, box_max_y_reg;
    coord_t prev_x_reg, prev_y_reg;
    logic   pending_reg;
    logic   mode_reg;
    coord_t nx_reg, ny_reg;
    coord_t px_reg, py_reg, qx_reg, qy_reg;
    coord_t edge_x_reg, edge_y_reg;
    mag_t   ax_reg, by_reg, ay_reg, bx_reg;
    logic   s_out_reg, e_out_reg, opens_reg, xo_reg, yo_reg, use_x_reg;
    coord_t res_sx_reg, res_sy_reg, res_ex_reg, res_ey_reg;
    prod_t  num_reg;
    mag_t   den_reg;
    logic   out_valid_reg;
    psbc_out_t out_reg;
    logic   mul_go_reg;
    logic   div_go_reg;

    logic   s_out, e_out, xo, yo, use_x, load_out;
    logic   mul_start, mul_done, mul2_done, div_done;
    prod_t  m1, m2;
    mag_t   quot;
    coord_t pb, lo_b, hi_b, clip_v;
    logic   up;
    logic signed [COORD_BITS+1:0] r_wide, lo_w, hi_w;

    function automatic logic outside(input coord_t x, input coord_t y,
                                     input coord_t x0, input coord_t x1,
                                     input coord_t y0, input coord_t y1);
        return x < x0 || x > x1 || y < y0 || y > y1;
    endfunction

    assign s_out = outside(prev_x_reg, prev_y_reg, box_min_x_reg, box_max_x_reg,
                           box_min_y_reg, box_max_y_reg);
    assign e_out = outside(nx_reg, ny_reg, box_min_x_reg, box_max_x_reg,
                           box_min_y_reg, box_max_y_reg);
    assign xo    = qx_reg < box_min_x_reg || qx_reg > box_max_x_reg;
    assign yo    = qy_reg < box_min_y_reg || qy_reg > box_max_y_reg;
    assign use_x = xo_reg && (!yo_reg || m1 <= m2);

    assign pb     = use_x_reg ? py_reg : px_reg;
    assign up     = use_x_reg ? (qy_reg >= py_reg) : (qx_reg >= px_reg);
    assign lo_b   = use_x_reg ? box_min_y_reg : box_min_x_reg;
    assign hi_b   = use_x_reg ? box_max_y_reg : box_max_x_reg;
    assign r_wide = up ? ({{2{pb[COORD_BITS-1]}}, pb} + {1'b0, quot})
                       : ({{2{pb[COORD_BITS-1]}}, pb} - {1'b0, quot});
    assign lo_w   = {{2{lo_b[COORD_BITS-1]}}, lo_b};
    assign hi_w   = {{2{hi_b[COORD_BITS-1]}}, hi_b};
    assign clip_v = (r_wide < lo_w) ? lo_b
                  : (r_wide > hi_w) ? hi_b : r_wide[COORD_BITS-1:0];

    assign in_ready  = (state_reg == ST_IDLE);
    assign mul_start = mul_go_reg;
    assign load_out  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    psbc_mul u_mul1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (ax_reg),
        .b       (by_reg),
        .done    (mul_done),
        .product (m1)
    );

    psbc_mul u_mul2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (ay_reg),
        .b       (bx_reg),
        .done    (mul2_done),
        .product (m2)
    );

    psbc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                if (!mode_reg || (s_out && e_out))
                begin
                    state_next = ST_IDLE;
                end
                else if (s_out || e_out)
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done && mul2_done)
                begin
                    state_next = ST_CHOOSE;
                end
            end
            ST_CHOOSE:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            box_min_x_reg <= '0;
            box_max_x_reg <= '0;
            box_min_y_reg <= '0;
            box_max_y_reg <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            pending_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            mul_go_reg    <= 1'b0;
            div_go_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mul_go_reg <= (state_reg == ST_SETUP);
            div_go_reg <= (state_reg == ST_CHOOSE);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIN_X: box_min_x_reg <= cfg_data;
                    CFG_MAX_X: box_max_x_reg <= cfg_data;
                    CFG_MIN_Y: box_min_y_reg <= cfg_data;
                    CFG_MAX_Y: box_max_y_reg <= cfg_data;
                    default:   box_min_x_reg <= box_min_x_reg;
                endcase
            end
            if (state_reg == ST_CLASS)
            begin
                prev_x_reg <= nx_reg;
                prev_y_reg <= ny_reg;
                if (!mode_reg)
                begin
                    pending_reg <= 1'b1;
                end
                else if (!(s_out && e_out))
                begin
                    pending_reg <= e_out;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= in_data.mode;
            nx_reg   <= in_data.point_x;
            ny_reg   <= in_data.point_y;
        end
        if (state_reg == ST_CLASS)
        begin
            s_out_reg  <= s_out;
            e_out_reg  <= e_out;
            opens_reg  <= pending_reg || s_out;
            res_sx_reg <= prev_x_reg;
            res_sy_reg <= prev_y_reg;
            res_ex_reg <= nx_reg;
            res_ey_reg <= ny_reg;
            px_reg     <= s_out ? nx_reg : prev_x_reg;
            py_reg     <= s_out ? ny_reg : prev_y_reg;
            qx_reg     <= s_out ? prev_x_reg : nx_reg;
            qy_reg     <= s_out ? prev_y_reg : ny_reg;
        end
        if (state_reg == ST_SETUP)
        begin
            xo_reg     <= xo;
            yo_reg     <= yo;
            edge_x_reg <= (qx_reg > box_max_x_reg) ? box_max_x_reg : box_min_x_reg;
            edge_y_reg <= (qy_reg > box_max_y_reg) ? box_max_y_reg : box_min_y_reg;
        end
        if (state_reg == ST_CHOOSE)
        begin
            use_x_reg <= use_x;
            den_reg   <= use_x ? bx_reg : by_reg;
            num_reg   <= (use_x ? m1 : m2)
                       + prod_t'(use_x ? (bx_reg >> 1) : (by_reg >> 1));
        end
        if (state_reg == ST_RES)
        begin
            if (s_out_reg)
            begin
                res_sx_reg <= use_x_reg ? edge_x_reg : clip_v;
                res_sy_reg <= use_x_reg ? clip_v : edge_y_reg;
            end
            else
            begin
                res_ex_reg <= use_x_reg ? edge_x_reg : clip_v;
                res_ey_reg <= use_x_reg ? clip_v : edge_y_reg;
            end
        end
        if (load_out)
        begin
            out_reg.seg_start_x       <= res_sx_reg;
            out_reg.seg_start_y       <= res_sy_reg;
            out_reg.seg_end_x         <= res_ex_reg;
            out_reg.seg_end_y         <= res_ey_reg;
            out_reg.start_was_clipped <= s_out_reg;
            out_reg.end_was_clipped   <= e_out_reg;
            out_reg.opens_polyline    <= opens_reg;
            out_reg.closes_polyline   <= e_out_reg;
        end
    end

    // Edge magnitudes are formed in the setup cycle, and the multipliers load them in the
    // cycle that follows.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            ax_reg <= absdiff((qx_reg > box_max_x_reg) ? box_max_x_reg : box_min_x_reg,
                              px_reg);
            ay_reg <= absdiff((qy_reg > box_max_y_reg) ? box_max_y_reg : box_min_y_reg,
                              py_reg);
            by_reg <= absdiff(qy_reg, py_reg);
            bx_reg <= absdiff(qx_reg, px_reg);
        end
    end

endmodule

// ----- rtl/psbc_checker.sv -----
`include "assert_macros.svh"

module psbc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input psbc_pkg::psbc_out_t out_data
);
    import psbc_pkg::*;

    `PSBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `PSBC_ASSERT_SAME(a_close_eq_end, clk, rst_n, out_valid, out_data.closes_polyline == out_data.end_was_clipped)
    `PSBC_ASSERT_SAME(a_one_end_clipped, clk, rst_n, out_valid, !(out_data.start_was_clipped && out_data.end_was_clipped))
    `PSBC_ASSERT_SAME(a_clipped_start_opens, clk, rst_n, out_valid && out_data.start_was_clipped, out_data.opens_polyline)

endmodule

bind polyline_segment_box_clipper_top psbc_checker u_psbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- tb/tb.sv -----
module tb;
    import psbc_pkg::*;

    localparam longint CMAX = 64'sd8388607;
    localparam longint CMIN = -64'sd8388608;

    class clip_scoreboard;
        longint bx0, bx1, by0, by1;
        longint pen_x, pen_y;
        bit new_line;
        psbc_out_t pending_q[$];
        int seen;

        function new();
            bx0 = 0; bx1 = 0; by0 = 0; by1 = 0;
            pen_x = 0; pen_y = 0;
            new_line = 1;
            seen = 0;
        endfunction

        function void write_box(cfg_idx_t idx, coord_t v);
            case (idx)
                CFG_MIN_X: bx0 = longint'(v);
                CFG_MAX_X: bx1 = longint'(v);
                CFG_MIN_Y: by0 = longint'(v);
                CFG_MAX_Y: by1 = longint'(v);
                default: ;
            endcase
        endfunction

        function longint unsigned absdist(longint a, longint b);
            return (a >= b) ? longint'(a - b) : longint'(b - a);
        endfunction

        function bit in_box(longint x, longint y);
            return x >= bx0 && x <= bx1 && y >= by0 && y <= by1;
        endfunction

        function longint limit(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint along(longint e, longint pa, longint qa, longint pb, longint qb);
            longint unsigned num, den, q;
            num = absdist(e, pa) * absdist(qb, pb);
            den = absdist(qa, pa);
            q = (den == 0) ? 0 : (num + (den >> 1)) / den;
            return (qb >= pb) ? pb + longint'(q) : pb - longint'(q);
        endfunction

        function void edge_point(longint px, longint py, longint qx, longint qy,
                                 output longint rx, output longint ry);
            bit xo, yo, on_x;
            longint ex, ey;
            xo = qx < bx0 || qx > bx1;
            yo = qy < by0 || qy > by1;
            ex = (qx > bx1) ? bx1 : bx0;
            ey = (qy > by1) ? by1 : by0;
            on_x = xo;
            if (xo && yo)
                on_x = absdist(ex, px) * absdist(qy, py) <= absdist(ey, py) * absdist(qx, px);
            if (on_x)
            begin
                rx = ex;
                ry = limit(along(ex, px, qx, py, qy), by0, by1);
            end
            else
            begin
                ry = ey;
                rx = limit(along(ey, py, qy, px, qx), bx0, bx1);
            end
        endfunction

        function void note(psbc_in_t w);
            longint nx, ny, sx, sy, ex, ey;
            bit s_out, e_out;
            psbc_out_t r;
            nx = longint'(w.point_x);
            ny = longint'(w.point_y);
            sx = pen_x; sy = pen_y; ex = nx; ey = ny;
            pen_x = nx;
            pen_y = ny;
            if (!w.mode)
            begin
                new_line = 1;
                return;
            end
            s_out = !in_box(sx, sy);
            e_out = !in_box(nx, ny);
            if (s_out && e_out)
                return;
            if (s_out)
                edge_point(nx, ny, sx, sy, sx, sy);
            else if (e_out)
                edge_point(sx, sy, nx, ny, ex, ey);
            r.seg_start_x = coord_t'(sx);
            r.seg_start_y = coord_t'(sy);
            r.seg_end_x = coord_t'(ex);
            r.seg_end_y = coord_t'(ey);
            r.start_was_clipped = s_out;
            r.end_was_clipped = e_out;
            r.opens_polyline = new_line || s_out;
            r.closes_polyline = e_out;
            new_line = e_out;
            pending_q.push_back(r);
        endfunction

        function string check(psbc_out_t r);
            psbc_out_t e;
            string s;
            seen++;
            if (pending_q.size() == 0)
                return "segment arrived with none expected";
            e = pending_q.pop_front();
            s = "";
            if (r.seg_start_x !== e.seg_start_x) s = {s, " seg_start_x"};
            if (r.seg_start_y !== e.seg_start_y) s = {s, " seg_start_y"};
            if (r.seg_end_x !== e.seg_end_x) s = {s, " seg_end_x"};
            if (r.seg_end_y !== e.seg_end_y) s = {s, " seg_end_y"};
            if (r.start_was_clipped !== e.start_was_clipped) s = {s, " start_was_clipped"};
            if (r.end_was_clipped !== e.end_was_clipped) s = {s, " end_was_clipped"};
            if (r.opens_polyline !== e.opens_polyline) s = {s, " opens_polyline"};
            if (r.closes_polyline !== e.closes_polyline) s = {s, " closes_polyline"};
            if (s != "")
                s = $sformatf("segment %0d wrong:%s got %h expected %h", seen, s, r, e);
            return s;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    psbc_in_t in_data;
    logic out_valid;
    logic out_ready;
    psbc_out_t out_data;
    logic cfg_we;
    logic [CFG_BITS-1:0] cfg_index;
    coord_t cfg_data;

    clip_scoreboard sb;
    int errors = 0;
    int words_sent = 0;
    bit hold_req = 0;

    polyline_segment_box_clipper_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("Some tests failed");
        $finish;
    end

    task report(input string s);
        $display("MISMATCH: %s", s);
        errors++;
    endtask

    task send(input bit m, input longint x, input longint y);
        int unsigned gap;
        psbc_in_t w;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        w.mode = m;
        w.point_x = coord_t'(x);
        w.point_y = coord_t'(y);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (!in_ready);
        sb.note(w);
        words_sent++;
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task set_box(input longint x0, input longint x1, input longint y0, input longint y1);
        cfg_idx_t idx;
        longint v [4];
        v[0] = x0; v[1] = x1; v[2] = y0; v[3] = y1;
        drain();
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_idx_t'(i);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= coord_t'(v[i]);
            @(posedge clk);
            sb.write_box(idx, coord_t'(v[i]));
        end
        cfg_we <= 1'b0;
    endtask

    function longint pick(longint lo, longint hi);
        longint a, b;
        a = (lo < CMIN) ? CMIN : lo;
        b = (hi > CMAX) ? CMAX : hi;
        if (b < a)
        begin
            a = CMIN;
            b = CMAX;
        end
        return a + longint'($urandom_range(0, int'(b - a)));
    endfunction

    task random_run(input int n);
        longint span_x, span_y, x, y;
        bit m;
        span_x = (sb.bx1 > sb.bx0) ? sb.bx1 - sb.bx0 : 1024;
        span_y = (sb.by1 > sb.by0) ? sb.by1 - sb.by0 : 1024;
        for (int i = 0; i < n; i++)
        begin
            m = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) < 7)
            begin
                x = pick(sb.bx0 - span_x / 2, sb.bx0 + span_x + span_x / 2);
                y = pick(sb.by0 - span_y / 2, sb.by0 + span_y + span_y / 2);
            end
            else
            begin
                x = longint'(coord_t'($urandom));
                y = longint'(coord_t'($urandom));
            end
            send(m, x, y);
        end
    endtask

    always
    begin
        int unsigned stall;
        string msg;
        if (hold_req)
        begin
            out_ready <= 1'b0;
            repeat (400) @(posedge clk);
            hold_req = 0;
        end
        stall = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0)
            stall = 0;
        if (stall > 0)
        begin
            out_ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!out_valid);
        msg = sb.check(out_data);
        if (msg != "")
            report(msg);
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset box is the single point at the origin.
        send(1, 0, 0);
        send(1, 256, 0);
        send(1, 0, 0);

        set_box(-256000, 256000, -128000, 128000);
        send(0, 0, 0);
        send(1, 1000, 2000);
        send(1, 256000, 128000);
        send(1, 600000, 100000);
        send(1, 0, 0);
        send(1, CMAX, CMAX);
        send(1, CMIN, CMIN);
        send(1, -300000, 0);
        send(1, 0, 0);
        send(0, 10, 10);
        send(1, 512000, 256000);
        send(1, CMAX, CMIN);
        send(0, 0, 0);
        send(1, 300000, -400000);
        send(0, 255999, 0);
        send(1, -256001, 5);
        send(1, CMIN, CMAX);
        send(1, 100, -100);
        random_run(150);

        hold_req = 1;
        random_run(40);
        drain();
        random_run(100);

        set_box(CMIN, CMAX, CMIN, CMAX);
        send(1, CMAX, CMIN);
        send(1, CMIN, CMAX);
        random_run(150);

        set_box(100, 50, -10, 10);
        random_run(60);

        set_box(-5000, -4000, 3000, 9000);
        random_run(250);

        set_box(-1, 1, CMIN, CMAX);
        random_run(150);

        set_box(-2000000, 3000000, -7000000, 1000000);
        random_run(300);

        drain();
        while (sb.pending_q.size() != 0)
        begin
            report("expected segment never arrived");
            void'(sb.pending_q.pop_front());
        end
        $display("Sent %0d points over seven box settings, checked %0d segments.",
                 words_sent, sb.seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
